// ===== rtl/assert_macros.svh =====
// Assertion macros used by cbq_cell, the RTL stage module of the cascaded biquad unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_HOLDS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that, when true, must be followed by another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cbq_pkg.sv =====
// Package for the cascaded biquad unit: sizes, action and coefficient codes,
// transaction types, the fixed-point rounding and saturation helpers and the channel slot helper.
// Used by cbq_cell and cascaded_biquad_filter_unit; depends on nothing.
package cbq_pkg;

  // Sizes of the filter bank.
  localparam int MAX_STAGES      = 4;
  localparam int MAX_CHANNELS    = 8;
  localparam int COEFS_PER_STAGE = 5;
  localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int CH_AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  // Action codes of an input transaction.
  localparam logic [1:0] ACT_FILTER = 2'd0;
  localparam logic [1:0] ACT_COEF   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Coefficient selects.
  localparam logic [2:0] SEL_B0 = 3'd0;
  localparam logic [2:0] SEL_B1 = 3'd1;
  localparam logic [2:0] SEL_B2 = 3'd2;
  localparam logic [2:0] SEL_A1 = 3'd3;
  localparam logic [2:0] SEL_A2 = 3'd4;

  // Input transaction.
  typedef struct packed {
    logic [1:0]          action;
    logic [2:0]          channel;
    logic signed [23:0]  sample_in;
    logic [1:0]          coef_stage;
    logic [2:0]          coef_select;
    logic signed [31:0]  coef_value;
  } in_item_t;

  // Result transaction.
  typedef struct packed {
    logic signed [23:0]  sample_out;
    logic [2:0]          channel_out;
    logic                saturated;
  } out_item_t;

  // Transaction as it travels from cell to cell.
  typedef struct packed {
    logic [1:0]          action;
    logic [2:0]          channel;
    logic signed [23:0]  x;
    logic                sat;
    logic [1:0]          coef_stage;
    logic [2:0]          coef_select;
    logic signed [31:0]  coef_value;
  } token_t;

  // Saturated values with their clip flag.
  typedef struct packed {
    logic               clip;
    logic signed [39:0] value;
  } sat40_t;

  typedef struct packed {
    logic               clip;
    logic signed [23:0] value;
  } sat24_t;

  // Round half up and drop 16 fraction bits: 47 to 31 fraction bits.
  function automatic logic signed [41:0] round16(input logic signed [56:0] v);
    logic signed [57:0] t;
    t = $signed({v[56], v}) + 58'sd32768;
    return $signed(t[57:16]);
  endfunction

  // Round half up and drop 8 fraction bits: 31 to 23 fraction bits.
  function automatic logic signed [35:0] round8(input logic signed [42:0] v);
    logic signed [43:0] t;
    t = $signed({v[42], v}) + 44'sd128;
    return $signed(t[43:8]);
  endfunction

  // Clip a sum to the 40-bit delay range.
  function automatic sat40_t sat40(input logic signed [42:0] v);
    sat40_t r;
    r.clip  = (v[42:39] != {4{v[42]}});
    r.value = r.clip ? {v[42], {39{~v[42]}}} : v[39:0];
    return r;
  endfunction

  // Clip a stage output to the 24-bit sample range.
  function automatic sat24_t sat24(input logic signed [35:0] v);
    sat24_t r;
    r.clip  = (v[35:23] != {13{v[35]}});
    r.value = r.clip ? {v[35], {23{~v[35]}}} : v[23:0];
    return r;
  endfunction

  // Channel number folded into the state slots (channel modulo MAX_CHANNELS).
  function automatic logic [CH_AW-1:0] chan_slot(input logic [2:0] ch);
    logic [6:0] v;
    v = 7'(ch);
    for (int i = 0; i < 8; i++) begin
      if (v >= 7'(MAX_CHANNELS)) begin
        v = v - 7'(MAX_CHANNELS);
      end
    end
    return CH_AW'(v);
  endfunction

endpackage

// ===== rtl/cascaded_biquad_filter_unit.sv =====
// Top level of the cascaded biquad unit: stage count register, a chain of
// cbq_cell stages and the result register. Depends on cbq_pkg and cbq_cell.
//
//   channel   handshake                  payload
//   input     in_valid / in_stall        in_data  (cbq_pkg::in_item_t)
//   output    out_valid / out_stall      out_data (cbq_pkg::out_item_t)
//   config    cfg_write                  cfg_data (stage count)
//
// Each cell holds a transaction through five multiply steps on the cell's one
// multiplier, a delay store and a hand-off when its stage is in use, and only for
// the hand-off otherwise; cells work on successive transactions at once, but a
// cell takes a new transaction only as its held one leaves. Reset clears
// coefficients, delay state and the stage count (to one). A stalled output holds
// its result while the chain keeps working until every cell holds a transaction.

module cascaded_biquad_filter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  cbq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cbq_pkg::out_item_t out_data
);

  localparam int LAST = cbq_pkg::MAX_STAGES;

  logic [2:0]      stage_count;
  logic            lk_valid [LAST+1];
  logic            lk_ready [LAST+1];
  cbq_pkg::token_t lk_tok   [LAST+1];
  logic            is_filter;

  // Stage count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_count <= 3'd1;
    end else if (cfg_write) begin
      stage_count <= cfg_data;
    end
  end

  // Input transaction enters the first cell directly.
  assign lk_valid[0] = in_valid;
  assign in_stall    = !lk_ready[0];

  always_comb begin
    lk_tok[0].action      = in_data.action;
    lk_tok[0].channel     = in_data.channel;
    lk_tok[0].x           = in_data.sample_in;
    lk_tok[0].sat         = 1'b0;
    lk_tok[0].coef_stage  = in_data.coef_stage;
    lk_tok[0].coef_select = in_data.coef_select;
    lk_tok[0].coef_value  = in_data.coef_value;
  end

  // Chain of stage cells.
  for (genvar s = 0; s < LAST; s++) begin : g_cell
    cbq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .index       (cbq_pkg::STAGE_W'(s)),
      .stage_count (stage_count),
      .up_valid    (lk_valid[s]),
      .up_ready    (lk_ready[s]),
      .up_tok      (lk_tok[s]),
      .dn_valid    (lk_valid[s+1]),
      .dn_ready    (lk_ready[s+1]),
      .dn_tok      (lk_tok[s+1])
    );
  end

  // Only filter transactions give a result; others leave the chain here.
  assign is_filter      = (lk_tok[LAST].action == cbq_pkg::ACT_FILTER);
  assign lk_ready[LAST] = !is_filter || !out_valid || !out_stall;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lk_valid[LAST] && lk_ready[LAST] && is_filter) begin
      out_valid            <= 1'b1;
      out_data.sample_out  <= lk_tok[LAST].x;
      out_data.channel_out <= lk_tok[LAST].channel;
      out_data.saturated   <= lk_tok[LAST].sat;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/cbq_cell.sv =====
// One biquad stage of the chain: coefficients, per-channel delay memory and
// a shared multiplier stepped by a small sequencer.
// Depends on cbq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cbq_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cbq_pkg::STAGE_W-1:0] index,
  input  logic [2:0]                  stage_count,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  cbq_pkg::token_t             up_tok,
  output logic                        dn_valid,
  input  logic                        dn_ready,
  output cbq_pkg::token_t             dn_tok
);

  localparam int CMP_W = (cbq_pkg::STAGE_W > 2) ? cbq_pkg::STAGE_W : 2;
  localparam int ACT_W = (cbq_pkg::STAGE_W > 3) ? cbq_pkg::STAGE_W : 3;

  // Each multiply state names the product that the multiplier forms in it.
  typedef enum logic [2:0] {
    S_IDLE, S_MB0, S_MB1, S_MA1, S_MB2, S_MA2, S_STORE, S_HOLD
  } state_t;

  state_t                   state;
  cbq_pkg::token_t          tok;
  logic [cbq_pkg::MAX_CHANNELS-1:0] vld;
  logic signed [31:0]       coef [cbq_pkg::COEFS_PER_STAGE];
  logic [79:0]              dmem [cbq_pkg::MAX_CHANNELS];

  logic signed [55:0]       prod;
  logic signed [55:0]       acc;
  logic signed [39:0]       rd_z1;
  logic signed [39:0]       rd_z2;
  logic signed [23:0]       y;
  logic signed [39:0]       z1n;

  logic                     accept;
  logic                     active;
  logic                     coef_hit;
  logic [cbq_pkg::CH_AW-1:0] slot;
  logic signed [31:0]       mul_coef;
  logic signed [23:0]       mul_opnd;
  logic signed [55:0]       mul_full;
  logic signed [56:0]       diff;
  logic signed [41:0]       y_r16;
  logic signed [42:0]       y_sum;
  cbq_pkg::sat24_t          y_sat;
  logic signed [41:0]       z_r16;
  cbq_pkg::sat40_t          z1_sat;
  cbq_pkg::sat40_t          z2_sat;

  // Handshake with the neighbors: a held transaction may leave while the next enters.
  assign up_ready = (state == S_IDLE) || ((state == S_HOLD) && dn_ready);
  assign accept   = up_valid && up_ready;
  assign dn_valid = (state == S_HOLD);
  assign dn_tok   = tok;

  // The first stage is always in use; the others follow the stage count.
  assign active   = (index == '0) || (ACT_W'(index) < ACT_W'(stage_count));
  assign coef_hit = (CMP_W'(up_tok.coef_stage) == CMP_W'(index)) &&
                    (up_tok.coef_select < 3'(cbq_pkg::COEFS_PER_STAGE));
  assign slot     = cbq_pkg::chan_slot(tok.channel);

  // Operand selection for the shared multiplier.
  always_comb begin
    case (state)
      S_MB0:   begin mul_coef = coef[cbq_pkg::SEL_B0]; mul_opnd = tok.x; end
      S_MB1:   begin mul_coef = coef[cbq_pkg::SEL_B1]; mul_opnd = tok.x; end
      S_MA1:   begin mul_coef = coef[cbq_pkg::SEL_A1]; mul_opnd = y;     end
      S_MB2:   begin mul_coef = coef[cbq_pkg::SEL_B2]; mul_opnd = tok.x; end
      S_MA2:   begin mul_coef = coef[cbq_pkg::SEL_A2]; mul_opnd = y;     end
      default: begin mul_coef = '0;                   mul_opnd = '0;    end
    endcase
  end

  assign mul_full = mul_coef * mul_opnd;

  // Stage output: b0*x rounded, plus the first delay word, then back to Q1.23.
  assign y_r16 = cbq_pkg::round16($signed({prod[55], prod}));
  assign y_sum = 43'(y_r16) + 43'(rd_z1);
  assign y_sat = cbq_pkg::sat24(cbq_pkg::round8(y_sum));

  // New delay words: forward product minus feedback product, then rounded.
  assign diff   = $signed({acc[55], acc}) - $signed({prod[55], prod});
  assign z_r16  = cbq_pkg::round16(diff);
  assign z1_sat = cbq_pkg::sat40(43'(z_r16) + 43'(rd_z2));
  assign z2_sat = cbq_pkg::sat40(43'(z_r16));

  // Sequencer, held transaction, coefficients and delay valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld   <= '0;
      for (int i = 0; i < cbq_pkg::COEFS_PER_STAGE; i++) begin
        coef[i] <= '0;
      end
    end else if (accept) begin
      tok <= up_tok;
      if ((up_tok.action == cbq_pkg::ACT_FILTER) && active) begin
        state <= S_MB0;
      end else begin
        state <= S_HOLD;
      end
      if (up_tok.action == cbq_pkg::ACT_CLEAR) begin
        vld <= '0;
      end
      if ((up_tok.action == cbq_pkg::ACT_COEF) && coef_hit) begin
        coef[up_tok.coef_select] <= up_tok.coef_value;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          state <= S_IDLE;
        end
        S_MB0: begin
          state <= S_MB1;
        end
        S_MB1: begin
          state   <= S_MA1;
          tok.sat <= tok.sat | y_sat.clip;
        end
        S_MA1: begin
          state <= S_MB2;
        end
        S_MB2: begin
          state   <= S_MA2;
          tok.sat <= tok.sat | z1_sat.clip;
        end
        S_MA2: begin
          state <= S_STORE;
        end
        S_STORE: begin
          state     <= S_HOLD;
          tok.x     <= y;
          tok.sat   <= tok.sat | z2_sat.clip;
          vld[slot] <= 1'b1;
        end
        S_HOLD: begin
          if (dn_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Product and intermediate registers.
  always_ff @(posedge clk) begin
    prod <= mul_full;
    case (state)
      S_MB1:   y   <= y_sat.value;
      S_MA1:   acc <= prod;
      S_MB2:   z1n <= z1_sat.value;
      S_MA2:   acc <= prod;
      default: ;
    endcase
  end

  // Delay memory: one word per channel holding both delay values.
  always_ff @(posedge clk) begin
    if (state == S_MB0) begin
      {rd_z1, rd_z2} <= vld[slot] ? dmem[slot] : '0;
    end
    if (state == S_STORE) begin
      dmem[slot] <= {z1n, z2_sat.value};
    end
  end

  `ASSERT_HOLDS(a_store_is_filter, (state != S_STORE) || (tok.action == cbq_pkg::ACT_FILTER), "delay store for a non-filter transaction")
  `ASSERT_NEXT(a_accept_leaves_idle, accept, state != S_IDLE, "accepted transaction was dropped")
  `ASSERT_NEXT(a_sat_sticky, (state != S_IDLE) && (state != S_HOLD) && tok.sat, tok.sat, "saturation flag lost during a stage")

endmodule
